// ===== rtl/bmpf_pkg.sv =====
// ----------------------------------------------------------------------------
// bmpf_pkg
// Shared types, register indexes and reset values for the button mode PWM
// fan controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmpf_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int CFG_ADDR_W     = 5;
  localparam int CFG_DATA_W     = 32;

  typedef enum logic [2:0] {
    REG_DEBOUNCE_MS     = 3'd0,
    REG_PAUSE_MS        = 3'd1,
    REG_BLINK_PERIOD    = 3'd2,
    REG_BLINK_THRESHOLD = 3'd3,
    REG_PWM_PERIOD      = 3'd4,
    REG_DUTY_STEP       = 3'd5,
    REG_MAX_MODE        = 3'd6
  } reg_idx_t;

  localparam logic [9:0]  DEBOUNCE_MS_RST     = 10'd20;
  localparam logic [15:0] PAUSE_MS_RST        = 16'd1000;
  localparam logic [11:0] BLINK_PERIOD_RST    = 12'd200;
  localparam logic [11:0] BLINK_THRESHOLD_RST = 12'd100;
  localparam logic [7:0]  PWM_PERIOD_RST      = 8'd10;
  localparam logic [7:0]  DUTY_STEP_RST       = 8'd2;
  localparam logic [3:0]  MAX_MODE_RST        = 4'd5;

  typedef struct packed {
    logic [9:0]  debounce_ms;
    logic [15:0] pause_ms;
    logic [11:0] blink_period;
    logic [11:0] blink_threshold;
    logic [7:0]  pwm_period;
    logic [7:0]  duty_step;
    logic [3:0]  max_mode;
  } cfg_t;

  typedef struct packed {
    logic       motor_on;
    logic       led_level;
    logic [3:0] mode_now;
    logic       in_pause;
  } res_t;

endpackage

// ===== rtl/bmpf_timer.sv =====
// ----------------------------------------------------------------------------
// bmpf_timer
// On-delay timer: first high sample clears the count, later high samples
// count up (saturating) until the preset is reached, then hold done.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmpf_timer #(
  parameter int CNT_W    = 16,
  parameter int PRESET_W = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                level,
  input  logic [PRESET_W-1:0] preset,
  output logic                q
);

  localparam int CMP_W = (CNT_W > PRESET_W) ? CNT_W : PRESET_W;

  logic             running_r, running_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] count_inc;

  assign count_inc = (&count_r) ? count_r : count_r + CNT_W'(1);

  always_comb begin
    running_nxt = running_r;
    done_nxt    = done_r;
    count_nxt   = count_r;
    q           = 1'b0;
    if (!level) begin
      running_nxt = 1'b0;
      done_nxt    = 1'b0;
    end else if (!running_r) begin
      running_nxt = 1'b1;
      done_nxt    = 1'b0;
      count_nxt   = '0;
    end else if (done_r) begin
      q = 1'b1;
    end else begin
      count_nxt = count_inc;
      if (CMP_W'(count_inc) >= CMP_W'(preset)) begin
        done_nxt = 1'b1;
        q        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      done_r    <= 1'b0;
      count_r   <= '0;
    end else if (en) begin
      running_r <= running_nxt;
      done_r    <= done_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

// ===== rtl/bmpf_regs.sv =====
// ----------------------------------------------------------------------------
// bmpf_regs
// APB-style configuration register file; always ready, reads return the
// stored register value, or zero for an unmapped index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmpf_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bmpf_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [bmpf_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [bmpf_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready,
  output bmpf_pkg::cfg_t                     cfg
);

  import bmpf_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms     <= DEBOUNCE_MS_RST;
      cfg_r.pause_ms        <= PAUSE_MS_RST;
      cfg_r.blink_period    <= BLINK_PERIOD_RST;
      cfg_r.blink_threshold <= BLINK_THRESHOLD_RST;
      cfg_r.pwm_period      <= PWM_PERIOD_RST;
      cfg_r.duty_step       <= DUTY_STEP_RST;
      cfg_r.max_mode        <= MAX_MODE_RST;
    end else if (wr_en) begin
      case (idx)
        REG_DEBOUNCE_MS:     cfg_r.debounce_ms     <= pwdata[9:0];
        REG_PAUSE_MS:        cfg_r.pause_ms        <= pwdata[15:0];
        REG_BLINK_PERIOD:    cfg_r.blink_period    <= pwdata[11:0];
        REG_BLINK_THRESHOLD: cfg_r.blink_threshold <= pwdata[11:0];
        REG_PWM_PERIOD:      cfg_r.pwm_period      <= pwdata[7:0];
        REG_DUTY_STEP:       cfg_r.duty_step       <= pwdata[7:0];
        REG_MAX_MODE:        cfg_r.max_mode        <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DEBOUNCE_MS:     prdata = CFG_DATA_W'(cfg_r.debounce_ms);
      REG_PAUSE_MS:        prdata = CFG_DATA_W'(cfg_r.pause_ms);
      REG_BLINK_PERIOD:    prdata = CFG_DATA_W'(cfg_r.blink_period);
      REG_BLINK_THRESHOLD: prdata = CFG_DATA_W'(cfg_r.blink_threshold);
      REG_PWM_PERIOD:      prdata = CFG_DATA_W'(cfg_r.pwm_period);
      REG_DUTY_STEP:       prdata = CFG_DATA_W'(cfg_r.duty_step);
      REG_MAX_MODE:        prdata = CFG_DATA_W'(cfg_r.max_mode);
      default:             prdata = '0;
    endcase
  end

endmodule

// ===== rtl/bmpf_core.sv =====
// ----------------------------------------------------------------------------
// bmpf_core
// Per-tick state update: debounce, mode select, blink code LED, pause and
// motor PWM. State advances once for each accepted request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmpf_core #(
  parameter int TIMER_BITS = bmpf_pkg::TIMER_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           switch_level,
  input  bmpf_pkg::cfg_t cfg,
  output bmpf_pkg::res_t res
);

  import bmpf_pkg::*;

  logic [7:0]  pwm_phase_r, pwm_phase_nxt;
  logic [11:0] blink_phase_r, blink_phase_nxt;
  logic        deb_prev_r, deb_prev_nxt;
  logic        blink_prev_r;
  logic [3:0]  mode_r, mode_nxt;
  logic        led_r, led_nxt;
  logic [3:0]  blink_cnt_r, blink_cnt_nxt;
  logic        pause_r, pause_nxt;
  logic        pause_set;

  logic        pressed;
  logic        pause_done;
  logic        blink_hi;
  logic [4:0]  mode_inc;
  logic [3:0]  blink_cnt_inc;
  logic [11:0] duty_lim;
  logic [8:0]  pwm_inc;
  logic [12:0] blink_inc;

  bmpf_timer #(
    .CNT_W    (TIMER_BITS),
    .PRESET_W (10)
  ) u_sw_timer (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .level  (switch_level),
    .preset (cfg.debounce_ms),
    .q      (pressed)
  );

  bmpf_timer #(
    .CNT_W    (TIMER_BITS),
    .PRESET_W (16)
  ) u_pause_timer (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .level  (pause_set),
    .preset (cfg.pause_ms),
    .q      (pause_done)
  );

  assign mode_inc = {1'b0, mode_r} + 5'd1;

  always_comb begin
    mode_nxt     = mode_r;
    deb_prev_nxt = deb_prev_r;
    if (pressed && !deb_prev_r) begin
      deb_prev_nxt = 1'b1;
      mode_nxt     = (mode_inc > {1'b0, cfg.max_mode}) ? 4'd0 : mode_inc[3:0];
    end else if (!pressed) begin
      deb_prev_nxt = 1'b0;
    end
  end

  assign blink_hi      = blink_phase_r > cfg.blink_threshold;
  assign blink_cnt_inc = blink_cnt_r + 4'd1;

  // step the blink code on a rising edge of the blink clock, outside the pause
  always_comb begin
    led_nxt       = led_r;
    blink_cnt_nxt = blink_cnt_r;
    pause_set     = pause_r;
    if (blink_hi && !blink_prev_r && !pause_r) begin
      if (!led_r) begin
        led_nxt       = 1'b1;
        blink_cnt_nxt = blink_cnt_inc;
        if (blink_cnt_inc >= mode_nxt) begin
          blink_cnt_nxt = 4'd0;
          pause_set     = 1'b1;
        end
      end else if (mode_nxt != 4'd0) begin
        led_nxt = 1'b0;
      end
    end
  end

  assign pause_nxt = pause_set & ~pause_done;

  assign duty_lim  = 12'(mode_nxt) * 12'(cfg.duty_step);
  assign pwm_inc   = {1'b0, pwm_phase_r} + 9'd1;
  assign blink_inc = {1'b0, blink_phase_r} + 13'd1;

  assign pwm_phase_nxt   = (pwm_inc >= {1'b0, cfg.pwm_period}) ? 8'd0 : pwm_inc[7:0];
  assign blink_phase_nxt = (blink_inc >= {1'b0, cfg.blink_period}) ? 12'd0 : blink_inc[11:0];

  always_comb begin
    res.motor_on  = {4'd0, pwm_phase_r} < duty_lim;
    res.led_level = led_nxt;
    res.mode_now  = mode_nxt;
    res.in_pause  = pause_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_phase_r   <= 8'd0;
      blink_phase_r <= 12'd0;
      deb_prev_r    <= 1'b0;
      blink_prev_r  <= 1'b0;
      mode_r        <= 4'd0;
      led_r         <= 1'b1;
      blink_cnt_r   <= 4'd0;
      pause_r       <= 1'b0;
    end else if (en) begin
      pwm_phase_r   <= pwm_phase_nxt;
      blink_phase_r <= blink_phase_nxt;
      deb_prev_r    <= deb_prev_nxt;
      blink_prev_r  <= blink_hi;
      mode_r        <= mode_nxt;
      led_r         <= led_nxt;
      blink_cnt_r   <= blink_cnt_nxt;
      pause_r       <= pause_nxt;
    end
  end

endmodule

// ===== rtl/button_mode_pwm_fan_controller_unit.sv =====
// ----------------------------------------------------------------------------
// button_mode_pwm_fan_controller_unit
// A request's result is registered into the output register when it is accepted.
// Accepts one request per cycle while no stalled result waits downstream.
// Synchronous active-low reset clears core state, LED lit, registers at defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_mode_pwm_fan_controller_unit #(
  parameter int TIMER_BITS = bmpf_pkg::TIMER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_switch_level,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_motor_on,
  output logic                            out_led_level,
  output logic [3:0]                      out_mode_now,
  output logic                            out_in_pause,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bmpf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bmpf_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bmpf_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  import bmpf_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t out_r;
  logic out_valid_r;
  logic in_acc;

  // hold input while a result waits downstream
  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  bmpf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bmpf_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (in_acc),
    .switch_level (in_switch_level),
    .cfg          (cfg),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_motor_on  = out_r.motor_on;
  assign out_led_level = out_r.led_level;
  assign out_mode_now  = out_r.mode_now;
  assign out_in_pause  = out_r.in_pause;

endmodule

// ===== tb/sv/button_mode_pwm_fan_controller_unit_test.sv =====
// ----------------------------------------------------------------------------
// button_mode_pwm_fan_controller_unit_test
// Drives one switch sample per request into the fan controller and checks every
// result (motor drive, LED pin, mode, pause flag) against a cycle-free predictor
// of the debounce, mode, blink-code and PWM logic. Settings are rewritten over
// the register port between phases, covering the extremes, zero periods and a
// zero top mode. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class fan_ctrl_tracker;

  typedef struct packed {
    logic                                  run;
    logic                                  done;
    logic [bmpf_pkg::TIMER_BITS_DEF-1:0]   cnt;
  } hold_timer_t;

  bmpf_pkg::cfg_t  regs;
  logic [7:0]      pwm_phase;
  logic [11:0]     blink_phase;
  hold_timer_t     press_timer;
  hold_timer_t     pause_timer;
  logic            press_prev;
  logic            blink_prev;
  logic            led;
  logic            pausing;
  logic [3:0]      mode;
  logic [3:0]      blinks;
  bmpf_pkg::res_t  due_ticks[$];
  int unsigned     mismatches;

  function new();
    regs.debounce_ms     = bmpf_pkg::DEBOUNCE_MS_RST;
    regs.pause_ms        = bmpf_pkg::PAUSE_MS_RST;
    regs.blink_period    = bmpf_pkg::BLINK_PERIOD_RST;
    regs.blink_threshold = bmpf_pkg::BLINK_THRESHOLD_RST;
    regs.pwm_period      = bmpf_pkg::PWM_PERIOD_RST;
    regs.duty_step       = bmpf_pkg::DUTY_STEP_RST;
    regs.max_mode        = bmpf_pkg::MAX_MODE_RST;
    pwm_phase   = '0;
    blink_phase = '0;
    press_timer = '0;
    pause_timer = '0;
    press_prev  = 1'b0;
    blink_prev  = 1'b0;
    led         = 1'b1;
    pausing     = 1'b0;
    mode        = '0;
    blinks      = '0;
    mismatches  = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] value);
    case (idx)
      bmpf_pkg::REG_DEBOUNCE_MS:     regs.debounce_ms     = value[9:0];
      bmpf_pkg::REG_PAUSE_MS:        regs.pause_ms        = value[15:0];
      bmpf_pkg::REG_BLINK_PERIOD:    regs.blink_period    = value[11:0];
      bmpf_pkg::REG_BLINK_THRESHOLD: regs.blink_threshold = value[11:0];
      bmpf_pkg::REG_PWM_PERIOD:      regs.pwm_period      = value[7:0];
      bmpf_pkg::REG_DUTY_STEP:       regs.duty_step       = value[7:0];
      bmpf_pkg::REG_MAX_MODE:        regs.max_mode        = value[3:0];
      default: ;
    endcase
  endfunction

  // Output of the on-delay timer equals its done bit after the step.
  function hold_timer_t step_timer(hold_timer_t t, logic level, logic [15:0] preset);
    if (!level) begin
      t.run  = 1'b0;
      t.done = 1'b0;
    end else if (!t.run) begin
      t.cnt  = '0;
      t.done = 1'b0;
      t.run  = 1'b1;
    end else if (!t.done) begin
      if (t.cnt != '1) t.cnt = t.cnt + 1'b1;
      if (t.cnt >= preset) t.done = 1'b1;
    end
    return t;
  endfunction

  function int unsigned next_phase(int unsigned phase, int unsigned period);
    int unsigned n;
    n = phase + 1;
    return (n >= period) ? 0 : n;
  endfunction

  function void note_tick(logic level);
    bmpf_pkg::res_t r;
    logic           blink_hi;
    int unsigned    m;
    press_timer = step_timer(press_timer, level, {6'd0, regs.debounce_ms});
    if (press_timer.done && !press_prev) begin
      press_prev = 1'b1;
      m = mode + 1;
      mode = (m > regs.max_mode) ? 4'd0 : 4'(m);
    end else if (!press_timer.done) begin
      press_prev = 1'b0;
    end

    blink_hi = blink_phase > regs.blink_threshold;
    if (blink_hi && !blink_prev && !pausing) begin
      if (!led) begin
        led    = 1'b1;
        blinks = blinks + 4'd1;
        if (blinks >= mode) begin
          blinks  = '0;
          pausing = 1'b1;
        end
      end else if (mode != 0) begin
        led = 1'b0;
      end
    end
    blink_prev = blink_hi;

    pause_timer = step_timer(pause_timer, pausing, regs.pause_ms);
    if (pause_timer.done) pausing = 1'b0;

    r.motor_on  = int'(pwm_phase) < int'(mode) * int'(regs.duty_step);
    r.led_level = led;
    r.mode_now  = mode;
    r.in_pause  = pausing;
    pwm_phase   = 8'(next_phase(pwm_phase, regs.pwm_period));
    blink_phase = 12'(next_phase(blink_phase, regs.blink_period));
    due_ticks.push_back(r);
  endfunction

  function void compare_field(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function void check_tick(bmpf_pkg::res_t got);
    bmpf_pkg::res_t want;
    if (due_ticks.size() == 0) begin
      $display("%0t: result with no request pending, expected none got %0d/%0d/%0d/%0d",
               $time, got.motor_on, got.led_level, got.mode_now, got.in_pause);
      mismatches++;
      return;
    end
    want = due_ticks.pop_front();
    compare_field("motor_on",  {3'd0, want.motor_on},  {3'd0, got.motor_on});
    compare_field("led_level", {3'd0, want.led_level}, {3'd0, got.led_level});
    compare_field("mode_now",  want.mode_now,          got.mode_now);
    compare_field("in_pause",  {3'd0, want.in_pause},  {3'd0, got.in_pause});
  endfunction

endclass

module button_mode_pwm_fan_controller_unit_test;

  import bmpf_pkg::*;

  localparam logic [2:0]  REG_UNMAPPED    = 3'd7;
  localparam int unsigned IDLE_LIMIT      = 1000;
  localparam int unsigned PHASES          = 12;
  localparam int unsigned TICKS_PER_PHASE = 35;
  localparam int unsigned DIRECTED_TICKS  = 22;
  localparam logic [0:DIRECTED_TICKS-1] DIRECTED_LEVELS = 22'b0101110111000011011100;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_switch_level;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_motor_on;
  logic                  out_led_level;
  logic [3:0]            out_mode_now;
  logic                  out_in_pause;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  fan_ctrl_tracker tracker = new();
  bit              steady;
  int unsigned     ticks_sent;
  int unsigned     idle_cycles;

  button_mode_pwm_fan_controller_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_switch_level (in_switch_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_motor_on    (out_motor_on),
    .out_led_level   (out_led_level),
    .out_mode_now    (out_mode_now),
    .out_in_pause    (out_in_pause),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic cfg_t make_cfg(int unsigned deb, int unsigned pause, int unsigned bper,
                                    int unsigned bthr, int unsigned pper, int unsigned duty,
                                    int unsigned top);
    cfg_t s;
    s.debounce_ms     = 10'(deb);
    s.pause_ms        = 16'(pause);
    s.blink_period    = 12'(bper);
    s.blink_threshold = 12'(bthr);
    s.pwm_period      = 8'(pper);
    s.duty_step       = 8'(duty);
    s.max_mode        = 4'(top);
    return s;
  endfunction

  // Mostly short timings so presses, blink groups and pauses all complete.
  function automatic cfg_t random_cfg();
    cfg_t s;
    s.debounce_ms  = ($urandom_range(0, 3) != 0) ? 10'($urandom_range(0, 6)) : 10'($urandom);
    s.pause_ms     = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 40)) : 16'($urandom);
    s.blink_period = ($urandom_range(0, 3) != 0) ? 12'($urandom_range(0, 24)) : 12'($urandom);
    s.blink_threshold = ($urandom_range(0, 3) != 0) ?
                        12'($urandom_range(0, s.blink_period)) : 12'($urandom);
    s.pwm_period   = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 16)) : 8'($urandom);
    s.duty_step    = 8'($urandom);
    s.max_mode     = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 4)) : 4'($urandom);
    return s;
  endfunction

  task automatic cfg_write(logic [2:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(cfg_t s);
    cfg_write(REG_DEBOUNCE_MS,     32'(s.debounce_ms));
    cfg_write(REG_PAUSE_MS,        32'(s.pause_ms));
    cfg_write(REG_BLINK_PERIOD,    32'(s.blink_period));
    cfg_write(REG_BLINK_THRESHOLD, 32'(s.blink_threshold));
    cfg_write(REG_PWM_PERIOD,      32'(s.pwm_period));
    cfg_write(REG_DUTY_STEP,       32'(s.duty_step));
    cfg_write(REG_MAX_MODE,        32'(s.max_mode));
  endtask

  task automatic send_tick(logic level);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_switch_level <= level;
    do @(posedge clk); while (in_stall);
    tracker.note_tick(level);
    ticks_sent++;
  endtask

  task automatic drain_results();
    while (tracker.due_ticks.size() != 0) @(posedge clk);
  endtask

  // Mostly full presses of random length around the debounce time, the rest
  // cut-short presses and raw noise.
  task automatic run_phase(int unsigned n_ticks, int unsigned debounce);
    int unsigned first;
    int unsigned highs;
    first = ticks_sent;
    while (ticks_sent - first < n_ticks) begin
      if ($urandom_range(0, 99) < 80) begin
        highs = debounce + 1 + $urandom_range(0, 3);
        if ($urandom_range(0, 7) == 0) highs = $urandom_range(1, debounce + 1);
        if (highs > 60) highs = $urandom_range(20, 60);
        repeat (highs) send_tick(1'b1);
        repeat ($urandom_range(1, 6)) send_tick(1'b0);
      end else begin
        repeat ($urandom_range(1, 4)) send_tick(1'($urandom));
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic run_out_stall();
    int unsigned n;
    out_stall <= 1'b0;
    forever begin
      repeat ($urandom_range(1, 8)) @(posedge clk);
      n = pick_gap();
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  endtask

  initial run_out_stall();

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_tick('{motor_on: out_motor_on, led_level: out_led_level,
                           mode_now: out_mode_now, in_pause: out_in_pause});
    end
  end

  // Abort when neither channel moves a request for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("button_mode_pwm_fan_controller_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cfg_t s;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_switch_level <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    steady          = 1'b0;
    ticks_sent      = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fast settings with no PWM period, single-step mode range, and a write
    // to an address past the register file that must be dropped.
    apply_settings(make_cfg(1, 1, 2, 0, 0, 255, 1));
    cfg_write(REG_UNMAPPED, $urandom);
    for (int i = 0; i < DIRECTED_TICKS; i++) send_tick(DIRECTED_LEVELS[i]);
    in_valid <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      steady = ($urandom_range(0, 3) == 0);
      case (p)
        0:       s = make_cfg(1000, 60000, 4095, 4094, 255, 255, 15);
        4:       s = make_cfg(1, 1, 2, 0, 1, 0, 1);
        8:       s = make_cfg(0, 0, 0, 0, 0, 1, 0);
        default: s = random_cfg();
      endcase
      apply_settings(s);
      run_phase(TICKS_PER_PHASE, s.debounce_ms);
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.due_ticks.size() == 0) begin
      $display("button_mode_pwm_fan_controller_unit verification clean");
    end else begin
      $display("button_mode_pwm_fan_controller_unit verification failed");
    end
    $finish;
  end

endmodule
